// ===== hdl/assert_macros.svh =====
// Assertion macros used by the slot pool top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lsp_pkg.sv =====
// Shared types, field widths and the lifetime aging function of the slot pool.
package lsp_pkg;

  // field widths
  localparam int LIFE_W     = 24;
  localparam int STEP_W     = 16;
  localparam int SLOT_W     = 10;
  localparam int TOTAL_W    = 11;
  localparam int STATUS_W   = 2;

  // stream word widths
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  // item kinds
  localparam logic KIND_SPAWN = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED = 2'd0,
    ST_FULL    = 2'd1,
    ST_TICKED  = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SPAWN = 6'b000100,
    S_TICK  = 6'b001000,
    S_DONE  = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  // lifetime minus step, saturating at zero
  function automatic logic [LIFE_W-1:0] age_life(input logic [LIFE_W-1:0] life,
                                                 input logic [STEP_W-1:0] step);
    logic [LIFE_W-1:0] step_x;
    step_x = LIFE_W'(step);
    if (life > step_x) begin
      return life - step_x;
    end
    return '0;
  endfunction

endpackage

// ===== hdl/lsp_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
module lsp_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/lifetime_slot_pool_unit.sv =====
// Slot pool top level: free-slot stack, slot memory and the item sequencer.
// Spawn: accept issues the stack read, S_SPAWN writes the slot, S_DONE issues the result word.
// Tick: the walk reads one slot memory entry per cycle, then S_DONE issues the result word.
// Items: one at a time; S_DONE waits for the output register to be free before returning to idle.
// Reset: synchronous; then a clearing pass over all SLOTS entries fills the free
// stack and clears the active bits, with s_tready low the whole time.
module lifetime_slot_pool_unit #(
  parameter int SLOTS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [23:0] spawn_lifetime, [39:24] tick_step
  input  logic [lsp_pkg::IN_DATA_W-1:0]     s_tdata,
  // [0] kind
  input  logic [lsp_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [9:0] slot_index, [20:10] active_total, [23:21] zero
  output logic [lsp_pkg::OUT_DATA_W-1:0]    m_tdata,
  // [1:0] status
  output logic [lsp_pkg::OUT_USER_W-1:0]    m_tuser
);

  import lsp_pkg::*;
  `include "assert_macros.svh"

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t             state;
  logic [IDX_W-1:0]   clr_idx;
  logic [CNT_W-1:0]   free_top;
  logic [CNT_W-1:0]   active_count;
  logic [CNT_W-1:0]   rd_ptr;
  logic               pipe_valid;
  logic [IDX_W-1:0]   pipe_idx;
  logic [LIFE_W-1:0]  life_r;
  logic [STEP_W-1:0]  step_r;
  status_t            res_status;
  logic [IDX_W-1:0]   res_slot;

  logic               in_fire;
  logic               out_free;

  logic               stk_wr_en;
  logic [IDX_W-1:0]   stk_wr_addr;
  logic [IDX_W-1:0]   stk_wr_data;
  logic               stk_rd_en;
  logic [IDX_W-1:0]   stk_rd_addr;
  logic [IDX_W-1:0]   stk_rd_data;

  logic               slot_wr_en;
  logic [IDX_W-1:0]   slot_wr_addr;
  logic [LIFE_W:0]    slot_wr_data;
  logic               slot_rd_en;
  logic [IDX_W-1:0]   slot_rd_addr;
  logic [LIFE_W:0]    slot_rd_data;

  logic               cur_active;
  logic [LIFE_W-1:0]  new_life;
  logic               expire;
  logic               visit;
  logic               push_ok;
  logic               walk_end;

  // handshake
  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  // pop read of the free stack, issued on accepting a spawn while the stack is not empty
  assign stk_rd_en   = in_fire && (s_tuser[0] == KIND_SPAWN) && (free_top != '0);
  assign stk_rd_addr = IDX_W'(free_top - 1'b1);

  // tick walk read, one slot per cycle
  assign slot_rd_en   = (state == S_TICK) && (rd_ptr != SLOTS_C);
  assign slot_rd_addr = rd_ptr[IDX_W-1:0];
  assign walk_end     = (state == S_TICK) && !slot_rd_en && !pipe_valid;

  // aging of the slot read in the previous cycle
  assign cur_active = slot_rd_data[LIFE_W];
  assign new_life   = age_life(slot_rd_data[LIFE_W-1:0], step_r);
  assign expire     = (new_life == '0);
  assign visit      = (state == S_TICK) && pipe_valid && cur_active;
  assign push_ok    = visit && expire && (free_top != SLOTS_C);

  // slot memory write select
  always_comb begin
    slot_wr_en   = 1'b0;
    slot_wr_addr = '0;
    slot_wr_data = '0;
    if (state == S_CLEAR) begin
      slot_wr_en   = 1'b1;
      slot_wr_addr = clr_idx;
    end else if (state == S_SPAWN) begin
      slot_wr_en   = 1'b1;
      slot_wr_addr = stk_rd_data;
      slot_wr_data = {1'b1, life_r};
    end else if (visit) begin
      slot_wr_en   = 1'b1;
      slot_wr_addr = pipe_idx;
      slot_wr_data = {~expire, new_life};
    end
  end

  // free stack write select: initial fill or push of an expired slot
  always_comb begin
    stk_wr_en   = 1'b0;
    stk_wr_addr = '0;
    stk_wr_data = '0;
    if (state == S_CLEAR) begin
      stk_wr_en   = 1'b1;
      stk_wr_addr = clr_idx;
      stk_wr_data = LAST_IDX - clr_idx;
    end else if (push_ok) begin
      stk_wr_en   = 1'b1;
      stk_wr_addr = free_top[IDX_W-1:0];
      stk_wr_data = pipe_idx;
    end
  end

  lsp_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  lsp_ram #(.DEPTH(SLOTS), .WIDTH(LIFE_W + 1)) u_slots (
    .clk     (clk),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data)
  );

  // sequencer and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      free_top     <= SLOTS_C;
      active_count <= '0;
      rd_ptr       <= '0;
      pipe_valid   <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            life_r <= s_tdata[LIFE_W-1:0];
            step_r <= s_tdata[LIFE_W +: STEP_W];
            if (s_tuser[0] == KIND_TICK) begin
              rd_ptr     <= '0;
              pipe_valid <= 1'b0;
              state      <= S_TICK;
            end else if (free_top == '0) begin
              res_status <= ST_FULL;
              res_slot   <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_SPAWN;
            end
          end
        end
        S_SPAWN: begin
          free_top     <= free_top - 1'b1;
          active_count <= active_count + 1'b1;
          res_status   <= ST_GRANTED;
          res_slot     <= stk_rd_data;
          state        <= S_DONE;
        end
        S_TICK: begin
          pipe_valid <= slot_rd_en;
          pipe_idx   <= slot_rd_addr;
          if (slot_rd_en) begin
            rd_ptr <= rd_ptr + 1'b1;
          end
          if (push_ok) begin
            free_top <= free_top + 1'b1;
          end
          if (visit && expire && (active_count != '0)) begin
            active_count <= active_count - 1'b1;
          end
          if (walk_end) begin
            res_status <= ST_TICKED;
            res_slot   <= '0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_tdata <= OUT_DATA_W'({TOTAL_W'(active_count), SLOT_W'(res_slot)});
      m_tuser <= res_status;
    end
  end

  // checks
  `ASSERT_IMPL(a_pool_balance, clk, rst, state == S_IDLE,
               free_top + active_count == SLOTS_C, "free plus active slots differ from pool size")
  `ASSERT_IMPL(a_top_bound, clk, rst, 1'b1, free_top <= SLOTS_C, "free stack pointer beyond pool")
  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, active_count <= SLOTS_C, "active count beyond pool")
  `ASSERT_NEXT(a_one_item, clk, rst, in_fire, !s_tready, "second word taken while item in work")
  `ASSERT_IMPL(a_result_src, clk, rst, $rose(m_tvalid), $past(state) == S_DONE,
               "result word raised outside completion")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the slot pool: spawn/tick words in, grant/tick words checked out.
`timescale 1ns / 1ps

module tb_top;
  import lsp_pkg::*;

  localparam int SLOTS       = 1024;
  localparam int RAND_ITEMS  = 558;
  localparam int QUIET_LIMIT = 8 * SLOTS;

  // one output word, unpacked into its fields
  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [TOTAL_W-1:0]  total;
  } pool_word_t;

  // directed row: input fields, plus a hand-typed result when pinned is set
  typedef struct packed {
    logic               kind;
    logic [LIFE_W-1:0]  life;
    logic [STEP_W-1:0]  step;
    bit                 pinned;
    pool_word_t         want;
  } drill_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  // shadow pool state
  int unsigned       free_slots [SLOTS];
  int unsigned       free_top;
  bit                slot_live [SLOTS];
  logic [LIFE_W-1:0] slot_life [SLOTS];
  int unsigned       live_count;

  pool_word_t pending_words [$];
  drill_row_t drill [22];

  int unsigned mismatches = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned grants = 0;
  int unsigned refusals = 0;
  int unsigned ticks = 0;
  int unsigned expired = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  lifetime_slot_pool_unit #(.SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pool behavior for one accepted word; updates the shadow state
  function automatic pool_word_t pool_result(input logic kind,
                                             input logic [LIFE_W-1:0] life,
                                             input logic [STEP_W-1:0] step);
    pool_word_t  w;
    int unsigned slot;
    int unsigned i;
    w.status = ST_TICKED;
    w.slot   = '0;
    if (kind == KIND_SPAWN) begin
      if (free_top == 0) begin
        w.status = ST_FULL;
        refusals++;
      end else begin
        free_top--;
        slot = free_slots[free_top];
        slot_life[slot] = life;
        slot_live[slot] = 1'b1;
        live_count++;
        w.status = ST_GRANTED;
        w.slot   = SLOT_W'(slot);
        grants++;
      end
    end else begin
      ticks++;
      // walk in index order; expired slots go back on the stack in that order
      for (i = 0; i < SLOTS; i++) begin
        if (slot_live[i]) begin
          slot_life[i] = (slot_life[i] > LIFE_W'(step)) ? slot_life[i] - LIFE_W'(step) : '0;
          if (slot_life[i] == '0) begin
            slot_live[i] = 1'b0;
            if (free_top < SLOTS) begin
              free_slots[free_top] = i;
              free_top++;
            end
            if (live_count > 0) live_count--;
            expired++;
          end
        end
      end
    end
    w.total = TOTAL_W'(live_count);
    return w;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, what);
  endtask

  // drive one input word; called and returns at a falling edge
  task automatic push_item(input logic kind, input logic [LIFE_W-1:0] life,
                           input logic [STEP_W-1:0] step, input bit pinned,
                           input pool_word_t want);
    pool_word_t w;
    while (!calm && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {step, life};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_in++;
    w = pool_result(kind, life, step);
    pending_words.insert(pending_words.size(), pinned ? want : w);
    @(negedge clk);
  endtask

  // receiver backpressure
  always @(negedge clk) begin
    m_tready <= !rst && (calm || $urandom_range(99) >= 15);
  end

  // output check against the oldest expected word
  always @(posedge clk) begin
    pool_word_t exp_w;
    if (!rst && m_tvalid && m_tready) begin
      words_out++;
      if (pending_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word: status %0d slot %0d total %0d",
                                m_tuser, m_tdata[9:0], m_tdata[20:10]));
      end else begin
        exp_w = pending_words.pop_front();
        if (m_tuser !== exp_w.status || m_tdata[9:0] !== exp_w.slot ||
            m_tdata[20:10] !== exp_w.total || m_tdata[23:21] !== 3'b000) begin
          flag_mismatch($sformatf(
            "word %0d: expected status %0d slot %0d total %0d, got status %0d slot %0d total %0d pad %0d",
            words_out, exp_w.status, exp_w.slot, exp_w.total,
            m_tuser, m_tdata[9:0], m_tdata[20:10], m_tdata[23:21]));
        end
      end
    end
  end

  // watchdog: ends the run when no word moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles", QUIET_LIMIT);
      $display("lifetime_slot_pool_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned       k;
    int unsigned       n;
    logic              kind;
    logic [LIFE_W-1:0] life;
    logic [STEP_W-1:0] step;

    // shadow state after reset: slot 0 on top of the stack
    for (k = 0; k < SLOTS; k++) begin
      free_slots[k] = SLOTS - 1 - k;
      slot_live[k]  = 1'b0;
      slot_life[k]  = '0;
    end
    free_top   = SLOTS;
    live_count = 0;

    // directed rows; pinned results follow from reset order and plain arithmetic
    drill = '{
      '{KIND_TICK,  24'h000000, 16'h0000, 1'b1, '{ST_TICKED,  10'd0, 11'd0}}, // tick on empty pool
      '{KIND_SPAWN, 24'h000000, 16'hFFFF, 1'b1, '{ST_GRANTED, 10'd0, 11'd1}}, // zero lifetime
      '{KIND_SPAWN, 24'hFFFFFF, 16'h0000, 1'b1, '{ST_GRANTED, 10'd1, 11'd2}}, // max lifetime
      '{KIND_SPAWN, 24'h000001, 16'h5A5A, 1'b1, '{ST_GRANTED, 10'd2, 11'd3}},
      '{KIND_TICK,  24'hFFFFFF, 16'h0000, 1'b1, '{ST_TICKED,  10'd0, 11'd2}}, // zero step frees slot 0
      '{KIND_SPAWN, 24'h010000, 16'h0000, 1'b1, '{ST_GRANTED, 10'd0, 11'd3}}, // freed slot reused
      '{KIND_TICK,  24'h000000, 16'hFFFF, 1'b1, '{ST_TICKED,  10'd0, 11'd2}}, // saturates slot 2
      '{KIND_TICK,  24'h000000, 16'h0001, 1'b1, '{ST_TICKED,  10'd0, 11'd1}},
      '{KIND_SPAWN, 24'h001234, 16'h0000, 1'b0, '0},
      '{KIND_SPAWN, 24'hAAAAAA, 16'h5555, 1'b0, '0},
      '{KIND_SPAWN, 24'h555555, 16'hAAAA, 1'b0, '0},
      '{KIND_TICK,  24'h000000, 16'h1234, 1'b0, '0}, // step equals lifetime
      '{KIND_SPAWN, 24'h000100, 16'h0000, 1'b0, '0},
      '{KIND_TICK,  24'h555555, 16'hAAAA, 1'b0, '0},
      '{KIND_TICK,  24'hAAAAAA, 16'h5555, 1'b0, '0},
      '{KIND_SPAWN, 24'h000000, 16'h0000, 1'b0, '0},
      '{KIND_SPAWN, 24'h000000, 16'h0000, 1'b0, '0},
      '{KIND_TICK,  24'h000000, 16'hFFFF, 1'b0, '0}, // two zero-life slots freed together
      '{KIND_SPAWN, 24'hFFFFFF, 16'hFFFF, 1'b0, '0},
      '{KIND_SPAWN, 24'h000002, 16'h0000, 1'b0, '0},
      '{KIND_TICK,  24'h000000, 16'h0000, 1'b0, '0},
      '{KIND_TICK,  24'hFFFFFF, 16'h8000, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < $size(drill); k++) begin
      push_item(drill[k].kind, drill[k].life, drill[k].step, drill[k].pinned, drill[k].want);
    end

    // random mix of spawns and ticks
    for (n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 100 && n < 220);
      kind = ($urandom_range(99) < 30) ? KIND_TICK : KIND_SPAWN;
      case ($urandom_range(9))
        0, 1:       life = LIFE_W'($urandom_range(15));
        2, 3, 4, 5: life = LIFE_W'($urandom_range(24'h30000));
        6, 7, 8:    life = LIFE_W'($urandom_range(24'hFFFFF));
        default:    life = LIFE_W'($urandom());
      endcase
      case ($urandom_range(3))
        0, 1:    step = STEP_W'($urandom());
        2:       step = STEP_W'($urandom_range(255));
        default: step = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
      push_item(kind, life, step, 1'b0, '0);
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    // drain, then watch for stray words over one full tick walk
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SLOTS + 16) @(posedge clk);

    $display("run: %0d words in, %0d out; %0d grants, %0d refusals on a full pool",
             words_in, words_out, grants, refusals);
    $display("run: %0d ticks expired %0d slots; %0d mismatches", ticks, expired, mismatches);
    if (mismatches == 0) begin
      $display("lifetime_slot_pool_unit: match");
    end else begin
      $display("lifetime_slot_pool_unit: mismatch");
    end
    $finish;
  end

endmodule
